### rtl/fvf2vd_pkg.sv
`default_nettype none

package fvf2vd_pkg;

  localparam int unsigned MAX_TEXCOORDS = 8;

  // Slots ahead of the texcoords: position, weights, indices, normal,
  // psize, diffuse, specular.
  localparam int unsigned NUM_FIXED = 7;

  localparam int unsigned SLOT_POS      = 0;
  localparam int unsigned SLOT_WEIGHT   = 1;
  localparam int unsigned SLOT_INDICES  = 2;
  localparam int unsigned SLOT_NORMAL   = 3;
  localparam int unsigned SLOT_PSIZE    = 4;
  localparam int unsigned SLOT_DIFFUSE  = 5;
  localparam int unsigned SLOT_SPECULAR = 6;

  localparam logic [1:0] KIND_ELEMENT = 2'd0;
  localparam logic [1:0] KIND_TERM    = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RESERVED = 2'd1;
  localparam logic [1:0] ERR_TEXCOUNT = 2'd2;
  localparam logic [1:0] ERR_WEIGHTS  = 2'd3;

  localparam logic [2:0] T_FLOAT1 = 3'd0;
  localparam logic [2:0] T_FLOAT2 = 3'd1;
  localparam logic [2:0] T_FLOAT3 = 3'd2;
  localparam logic [2:0] T_FLOAT4 = 3'd3;
  localparam logic [2:0] T_COLOR  = 3'd4;
  localparam logic [2:0] T_UBYTE4 = 3'd5;

  localparam logic [2:0] U_POSITION     = 3'd0;
  localparam logic [2:0] U_BLENDWEIGHT  = 3'd1;
  localparam logic [2:0] U_BLENDINDICES = 3'd2;
  localparam logic [2:0] U_NORMAL       = 3'd3;
  localparam logic [2:0] U_PSIZE        = 3'd4;
  localparam logic [2:0] U_TEXCOORD     = 3'd5;
  localparam logic [2:0] U_POSITIONT    = 3'd6;
  localparam logic [2:0] U_COLOR        = 3'd7;

  // Decoded slot before offsets are known; size in bytes (4..16).
  typedef struct packed {
    logic [2:0] elem_type;
    logic [2:0] usage;
    logic [2:0] usage_index;
    logic [4:0] size;
  } slot_t;

  // Slot with its final byte offset.
  typedef struct packed {
    logic [2:0] elem_type;
    logic [2:0] usage;
    logic [2:0] usage_index;
    logic [7:0] offset;
  } elem_t;

endpackage

`default_nettype wire

### rtl/fvf2vd_if.sv
`default_nettype none

interface fvf2vd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] fvf_code;

  modport source (output valid, output fvf_code, input ready);
  modport sink   (input valid, input fvf_code, output ready);
endinterface

interface fvf2vd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] entry_kind;
  logic [1:0] error_code;
  logic [7:0] byte_offset;
  logic [2:0] element_type;
  logic [2:0] usage;
  logic [2:0] usage_index;
  logic       last;

  modport source (output valid, output entry_kind, output error_code, output byte_offset,
                  output element_type, output usage, output usage_index, output last,
                  input ready);
  modport sink   (input valid, input entry_kind, input error_code, input byte_offset,
                  input element_type, input usage, input usage_index, input last,
                  output ready);
endinterface

`default_nettype wire

### rtl/fvf2vd_emit.sv
`default_nettype none

// Walks a loaded slot table lowest slot first, one result per cycle unless the output
// stalls, into a registered output.
module fvf2vd_emit #(
  parameter int unsigned MaxTexcoords = fvf2vd_pkg::MAX_TEXCOORDS
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   ld_valid_i,
  output logic                  ld_ready_o,
  input  wire [fvf2vd_pkg::NUM_FIXED+MaxTexcoords:0] ld_mask_i,
  input  fvf2vd_pkg::elem_t     ld_ent_i [fvf2vd_pkg::NUM_FIXED+MaxTexcoords+1],
  input  wire [1:0]             ld_err_i,
  fvf2vd_out_if.source          out_o
);

  localparam int unsigned NSlot = fvf2vd_pkg::NUM_FIXED + MaxTexcoords + 1;

  logic [NSlot-1:0]   mask_q;
  fvf2vd_pkg::elem_t  ent_q [NSlot];
  logic [1:0]         err_q;

  logic [NSlot-1:0]   first;
  logic [NSlot-1:0]   rest;
  fvf2vd_pkg::elem_t  sel;
  logic               busy, adv, last_now, load;
  logic               out_valid_q;
  logic [1:0]         kind_d;
  logic [1:0]         err_d;

  assign first    = mask_q & (~mask_q + NSlot'(1));
  assign rest     = mask_q & ~first;
  assign busy     = |mask_q;
  assign adv      = busy && (!out_valid_q || out_o.ready);
  assign last_now = (rest == '0);
  assign ld_ready_o = !busy || (adv && last_now);
  assign load     = ld_valid_i && ld_ready_o;

  // one-hot select of the lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = 0; i < NSlot; i++) begin
      if (first[i]) begin
        sel = sel | ent_q[i];
      end
    end
  end

  always_comb begin
    kind_d = fvf2vd_pkg::KIND_ELEMENT;
    err_d  = fvf2vd_pkg::ERR_NONE;
    if (first[NSlot-1]) begin
      if (err_q != fvf2vd_pkg::ERR_NONE) begin
        kind_d = fvf2vd_pkg::KIND_ERROR;
        err_d  = err_q;
      end else begin
        kind_d = fvf2vd_pkg::KIND_TERM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        mask_q <= ld_mask_i;
      end else if (adv) begin
        mask_q <= rest;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ent_q <= ld_ent_i;
      err_q <= ld_err_i;
    end
    if (adv) begin
      out_o.entry_kind   <= kind_d;
      out_o.error_code   <= err_d;
      out_o.byte_offset  <= sel.offset;
      out_o.element_type <= sel.elem_type;
      out_o.usage        <= sel.usage;
      out_o.usage_index  <= sel.usage_index;
      out_o.last         <= last_now;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/fvf_to_vertex_declaration.sv
// Path: stage 1 register, stage 2 register, emitter slot table, emitter output register.
// Throughput: one result per cycle from the emitter unless the output stalls; a code has
// 1 result for an error, 1 to NUM_FIXED + MaxTexcoords + 1 otherwise.
// Decode and offset stages take a new code every cycle and stall without loss.
// Reset (rst_ni, async, active low) empties every stage; no state survives between codes.
`default_nettype none

module fvf_to_vertex_declaration #(
  parameter int unsigned MaxTexcoords = fvf2vd_pkg::MAX_TEXCOORDS
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  fvf2vd_in_if.sink      in_i,
  fvf2vd_out_if.source   out_o
);

  localparam int unsigned NFix  = fvf2vd_pkg::NUM_FIXED;
  localparam int unsigned NEnt  = NFix + MaxTexcoords;   // slots without terminator
  localparam int unsigned NSlot = NEnt + 1;

  // ---------------------------------------------------------------------------
  // Stage 1: decode the code into a fixed slot table plus a presence mask.
  // Slot order equals emission order; absent slots are simply masked off.
  // ---------------------------------------------------------------------------
  logic [31:0]        code;
  logic [15:0]        posv;
  logic [3:0]         ntex;
  logic [2:0]         weights;
  logic               beta;
  logic [1:0]         err1_d;
  logic [NEnt-1:0]    mask1_d;
  fvf2vd_pkg::slot_t  ent1_d [NEnt];
  logic [1:0]         tsz;

  logic               v1_q, rdy1;
  logic [1:0]         err1_q;
  logic [NEnt-1:0]    mask1_q;
  fvf2vd_pkg::slot_t  ent1_q [NEnt];

  assign code = in_i.fvf_code;
  assign posv = code[15:0] & 16'h400E;
  assign ntex = code[11:8];
  assign beta = code[12] | code[15];

  always_comb begin
    unique case (posv)
      16'h0006: weights = 3'd1;
      16'h0008: weights = 3'd2;
      16'h000A: weights = 3'd3;
      16'h000C: weights = 3'd4;
      16'h000E: weights = 3'd5;
      default:  weights = 3'd0;
    endcase
  end

  // error causes in priority order: reserved bits, texcoord count, weights
  always_comb begin
    priority if ((code & 32'h0000_2001) != 32'd0) begin
      err1_d = fvf2vd_pkg::ERR_RESERVED;
    end else if (ntex > 4'(MaxTexcoords)) begin
      err1_d = fvf2vd_pkg::ERR_TEXCOUNT;
    end else if (weights == 3'd5 && !beta) begin
      err1_d = fvf2vd_pkg::ERR_WEIGHTS;
    end else begin
      err1_d = fvf2vd_pkg::ERR_NONE;
    end
  end

  always_comb begin
    tsz = 2'd0;
    for (int i = 0; i < NEnt; i++) begin
      ent1_d[i] = '0;
    end
    mask1_d = '0;

    // position: XYZRHW and XYZW are float4, anything else nonzero is float3
    mask1_d[fvf2vd_pkg::SLOT_POS] = (posv != 16'd0);
    if (posv == 16'h0004) begin
      ent1_d[fvf2vd_pkg::SLOT_POS] = '{fvf2vd_pkg::T_FLOAT4, fvf2vd_pkg::U_POSITIONT,
                                       3'd0, 5'd16};
    end else if (posv == 16'h4002) begin
      ent1_d[fvf2vd_pkg::SLOT_POS] = '{fvf2vd_pkg::T_FLOAT4, fvf2vd_pkg::U_POSITION,
                                       3'd0, 5'd16};
    end else begin
      ent1_d[fvf2vd_pkg::SLOT_POS] = '{fvf2vd_pkg::T_FLOAT3, fvf2vd_pkg::U_POSITION,
                                       3'd0, 5'd12};
    end

    // blend weights; with last beta the final weight becomes the index element
    mask1_d[fvf2vd_pkg::SLOT_WEIGHT] = (weights != 3'd0) && (!beta || weights > 3'd1);
    if (beta) begin
      ent1_d[fvf2vd_pkg::SLOT_WEIGHT] = '{weights - 3'd2, fvf2vd_pkg::U_BLENDWEIGHT,
                                          3'd0, {weights - 3'd1, 2'b00}};
    end else begin
      ent1_d[fvf2vd_pkg::SLOT_WEIGHT] = '{weights - 3'd1, fvf2vd_pkg::U_BLENDWEIGHT,
                                          3'd0, {weights, 2'b00}};
    end
    mask1_d[fvf2vd_pkg::SLOT_INDICES] = (weights != 3'd0) && beta;
    ent1_d[fvf2vd_pkg::SLOT_INDICES] = '{code[12] ? fvf2vd_pkg::T_UBYTE4 : fvf2vd_pkg::T_COLOR,
                                         fvf2vd_pkg::U_BLENDINDICES, 3'd0, 5'd4};

    mask1_d[fvf2vd_pkg::SLOT_NORMAL]   = code[4];
    ent1_d[fvf2vd_pkg::SLOT_NORMAL]    = '{fvf2vd_pkg::T_FLOAT3, fvf2vd_pkg::U_NORMAL,
                                           3'd0, 5'd12};
    mask1_d[fvf2vd_pkg::SLOT_PSIZE]    = code[5];
    ent1_d[fvf2vd_pkg::SLOT_PSIZE]     = '{fvf2vd_pkg::T_FLOAT1, fvf2vd_pkg::U_PSIZE,
                                           3'd0, 5'd4};
    mask1_d[fvf2vd_pkg::SLOT_DIFFUSE]  = code[6];
    ent1_d[fvf2vd_pkg::SLOT_DIFFUSE]   = '{fvf2vd_pkg::T_COLOR, fvf2vd_pkg::U_COLOR,
                                           3'd0, 5'd4};
    mask1_d[fvf2vd_pkg::SLOT_SPECULAR] = code[7];
    ent1_d[fvf2vd_pkg::SLOT_SPECULAR]  = '{fvf2vd_pkg::T_COLOR, fvf2vd_pkg::U_COLOR,
                                           3'd1, 5'd4};

    // texcoords: size field 0..2 is float2..float4, 3 is float1
    for (int t = 0; t < MaxTexcoords; t++) begin
      tsz = code[16 + 2*t +: 2];
      mask1_d[NFix + t] = (4'(t) < ntex);
      if (tsz == 2'd3) begin
        ent1_d[NFix + t] = '{fvf2vd_pkg::T_FLOAT1, fvf2vd_pkg::U_TEXCOORD, 3'(t), 5'd4};
      end else begin
        ent1_d[NFix + t] = '{{1'b0, tsz} + 3'd1, fvf2vd_pkg::U_TEXCOORD, 3'(t),
                             {({1'b0, tsz} + 3'd2), 2'b00}};
      end
    end

    if (err1_d != fvf2vd_pkg::ERR_NONE) begin
      mask1_d = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: offsets as two independent prefix sums, fixed slots and texcoords.
  // ---------------------------------------------------------------------------
  logic               v2_q, rdy2;
  logic [1:0]         err2_q;
  logic [NEnt-1:0]    mask2_q;
  fvf2vd_pkg::slot_t  ent2_q [NEnt];
  logic [7:0]         off2_d [NEnt];
  logic [7:0]         off2_q [NEnt];
  logic [7:0]         suma_d, sumb_d, suma_q, sumb_q;

  always_comb begin
    suma_d = 8'd0;
    for (int i = 0; i < NFix; i++) begin
      off2_d[i] = suma_d;
      suma_d = suma_d + (mask1_q[i] ? {3'd0, ent1_q[i].size} : 8'd0);
    end
    sumb_d = 8'd0;
    for (int i = NFix; i < NEnt; i++) begin
      off2_d[i] = sumb_d;
      sumb_d = sumb_d + (mask1_q[i] ? {3'd0, ent1_q[i].size} : 8'd0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 (registered inside the emitter): rebase texcoord offsets, build the
  // terminator carrying the stride, or the error result on its own.
  // ---------------------------------------------------------------------------
  logic [NSlot-1:0]   ld_mask;
  fvf2vd_pkg::elem_t  ld_ent [NSlot];

  always_comb begin
    for (int i = 0; i < NEnt; i++) begin
      ld_ent[i].elem_type   = ent2_q[i].elem_type;
      ld_ent[i].usage       = ent2_q[i].usage;
      ld_ent[i].usage_index = ent2_q[i].usage_index;
      ld_ent[i].offset      = (i < NFix) ? off2_q[i] : suma_q + off2_q[i];
    end
    ld_ent[NEnt] = '0;
    if (err2_q == fvf2vd_pkg::ERR_NONE) begin
      ld_ent[NEnt].offset = suma_q + sumb_q;
    end
    ld_mask = {1'b1, mask2_q};
  end

  // elastic handshake: stage 1 takes data when empty or when it drains; stage 2 when the emitter can load
  assign rdy1       = !v1_q || rdy2;
  assign in_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_i.valid) begin
      err1_q  <= err1_d;
      mask1_q <= mask1_d;
      ent1_q  <= ent1_d;
    end
    if (rdy2 && v1_q) begin
      err2_q  <= err1_q;
      mask2_q <= mask1_q;
      ent2_q  <= ent1_q;
      off2_q  <= off2_d;
      suma_q  <= suma_d;
      sumb_q  <= sumb_d;
    end
  end

  fvf2vd_emit #(
    .MaxTexcoords (MaxTexcoords)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ld_valid_i (v2_q),
    .ld_ready_o (rdy2),
    .ld_mask_i  (ld_mask),
    .ld_ent_i   (ld_ent),
    .ld_err_i   (err2_q),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
